>>> hw/rtl/atab_pkg.sv
// Shared constants and types for the ATA task-file address builder.
// No dependencies; used by atab_div_pipe and ata_taskfile_address_builder_core.
`default_nettype none

package atab_pkg;

    // Block number width and divider geometry
    localparam int unsigned BLOCK_BITS_DEFAULT = 28;
    localparam int unsigned START_BLOCK_W      = 28;
    localparam int unsigned SECTOR_TOTAL_W     = 9;
    localparam int unsigned QBITS_PER_STAGE    = 4;

    // Divisor widths after normalisation
    localparam int unsigned HEADS_W = 5;
    localparam int unsigned SPT_W   = 6;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LBA_MODE    = 2'd0,
        CFG_HEAD_COUNT  = 2'd1,
        CFG_SPT         = 2'd2,
        CFG_DRIVE_BASE  = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic               LBA_MODE_RESET   = 1'b0;
    localparam logic [HEADS_W-1:0] HEADS_RESET      = 5'd16;
    localparam logic [SPT_W-1:0]   SPT_RESET        = 6'd63;
    localparam logic [7:0]         DRIVE_BASE_RESET = 8'hA0;
    localparam logic [HEADS_W-1:0] MAX_HEADS        = 5'd16;

    // Task-file codes
    localparam logic [7:0] OPC_READ_SECTORS  = 8'h20;
    localparam logic [7:0] OPC_WRITE_SECTORS = 8'h30;
    localparam logic [7:0] LBA_FLAG          = 8'h40;

endpackage

`default_nettype wire

>>> hw/rtl/atab_div_pipe.sv
// Pipelined restoring divider, QBITS_PER_STAGE quotient bits per register stage,
// with a sideband that travels alongside. Depends on atab_pkg.
`default_nettype none

module atab_div_pipe #(
    parameter int unsigned DIVIDEND_W = atab_pkg::BLOCK_BITS_DEFAULT,
    parameter int unsigned DIVISOR_W  = atab_pkg::SPT_W,
    parameter int unsigned SIDE_W     = 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       out_valid,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int unsigned STEPS  = atab_pkg::QBITS_PER_STAGE;
    localparam int unsigned STAGES = (DIVIDEND_W + STEPS - 1) / STEPS;
    localparam int unsigned ACC_W  = STAGES * STEPS;

    logic [STAGES-1:0]    valid_reg;
    logic [ACC_W-1:0]     acc_reg  [STAGES];
    logic [DIVISOR_W-1:0] rem_reg  [STAGES];
    logic [SIDE_W-1:0]    side_reg [STAGES];
    logic [ACC_W-1:0]     acc_next [STAGES];
    logic [DIVISOR_W-1:0] rem_next [STAGES];
    logic [SIDE_W-1:0]    side_next[STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [ACC_W-1:0]     acc_in;
        logic [DIVISOR_W-1:0] rem_in;

        if (g == 0) begin : g_first
            assign acc_in       = ACC_W'(dividend);
            assign rem_in       = '0;
            assign side_next[g] = side_in;
        end else begin : g_rest
            assign acc_in       = acc_reg[g-1];
            assign rem_in       = rem_reg[g-1];
            assign side_next[g] = side_reg[g-1];
        end

        // Shift one dividend bit into the remainder per step, subtract when it fits
        always_comb begin : step_logic
            logic [ACC_W-1:0]     a;
            logic [DIVISOR_W-1:0] r;
            logic [DIVISOR_W:0]   trial;
            a     = acc_in;
            r     = rem_in;
            trial = '0;
            for (int k = 0; k < STEPS; k++) begin
                trial = {r, a[ACC_W-1]};
                a     = {a[ACC_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor}) begin
                    r    = DIVISOR_W'(trial - {1'b0, divisor});
                    a[0] = 1'b1;
                end else begin
                    r = trial[DIVISOR_W-1:0];
                end
            end
            acc_next[g] = a;
            rem_next[g] = r;
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                acc_reg[g]  <= acc_next[g];
                rem_reg[g]  <= rem_next[g];
                side_reg[g] <= side_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = acc_reg[STAGES-1][DIVIDEND_W-1:0];
    assign remainder = rem_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/ata_taskfile_address_builder_core.sv
// From input transfer to result: spt divider stages, heads divider stages, then the output register.
// Throughput: one command per cycle when not stalled; the two divider pipelines and the output register set it.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn low, synchronous): all valid bits clear, configuration returns to
// CHS mode, 16 heads, 63 sectors per track, drive base 0xA0.
// Depends on atab_pkg and atab_div_pipe.
`default_nettype none

module ata_taskfile_address_builder_core #(
    parameter int unsigned BLOCK_BITS = atab_pkg::BLOCK_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Command input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] cmd, [28:1] start_block, [37:29] sector_total, [39:38] zero
    input  wire logic [39:0] s_tdata,

    // Task-file result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] count_byte, [15:8] sector_byte, [23:16] cyl_low_byte,
    // [31:24] cyl_high_byte, [39:32] drive_head_byte, [47:40] command_byte
    output logic [47:0]      m_tdata,
    // [0] range_error
    output logic             m_tuser,

    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [atab_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [atab_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned HW     = atab_pkg::HEADS_W;
    localparam int unsigned SW     = atab_pkg::SPT_W;
    localparam int unsigned SIDE1W = 1 + 8 + BLOCK_BITS;
    localparam int unsigned SIDE2W = SIDE1W + SW;

    // ------------------------------------------------------------------
    // Configuration registers. Divisors are normalised on write so that
    // the datapath never sees zero heads, zero sectors or more than 16 heads.
    // ------------------------------------------------------------------
    logic          lba_mode_reg;
    logic [HW-1:0] heads_reg;
    logic [SW-1:0] spt_reg;
    logic [7:0]    drive_base_reg;
    logic [HW-1:0] heads_next;
    logic [SW-1:0] spt_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        heads_next = cfg_data[HW-1:0];
        if (heads_next == '0) begin
            heads_next = HW'(1);
        end else if (heads_next > atab_pkg::MAX_HEADS) begin
            heads_next = atab_pkg::MAX_HEADS;
        end
        spt_next = cfg_data[SW-1:0];
        if (spt_next == '0) begin
            spt_next = SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lba_mode_reg   <= atab_pkg::LBA_MODE_RESET;
            heads_reg      <= atab_pkg::HEADS_RESET;
            spt_reg        <= atab_pkg::SPT_RESET;
            drive_base_reg <= atab_pkg::DRIVE_BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (atab_pkg::cfg_index_t'(cfg_index))
                atab_pkg::CFG_LBA_MODE:   lba_mode_reg   <= cfg_data[0];
                atab_pkg::CFG_HEAD_COUNT: heads_reg      <= heads_next;
                atab_pkg::CFG_SPT:        spt_reg        <= spt_next;
                atab_pkg::CFG_DRIVE_BASE: drive_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking. The whole pipeline moves on one advance strobe:
    // it halts only when a finished result sits unclaimed in the output
    // register, so no transfer is taken while a result waits.
    // ------------------------------------------------------------------
    logic                  advance;
    logic                  in_cmd;
    logic [BLOCK_BITS-1:0] in_block;
    logic [7:0]            in_count;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign in_cmd   = s_tdata[0];
    assign in_block = s_tdata[BLOCK_BITS:1];
    assign in_count = s_tdata[36:29];   // low 8 bits of sector_total: 256 wraps to 0

    // ------------------------------------------------------------------
    // CHS translation as two chained divides:
    //   q1 = block / spt,  sector = block % spt + 1
    //   cyl = q1 / heads,  head = q1 % heads
    // which equals block / (heads*spt) and (block % (heads*spt)) / spt.
    // ------------------------------------------------------------------
    logic                  d1_valid;
    logic [BLOCK_BITS-1:0] d1_quot;
    logic [SW-1:0]         d1_rem;
    logic [SIDE1W-1:0]     d1_side;

    atab_div_pipe #(
        .DIVIDEND_W (BLOCK_BITS),
        .DIVISOR_W  (SW),
        .SIDE_W     (SIDE1W)
    ) u_div_spt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .dividend  (in_block),
        .divisor   (spt_reg),
        .side_in   ({in_cmd, in_count, in_block}),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .remainder (d1_rem),
        .side_out  (d1_side)
    );

    logic                  d2_valid;
    logic [BLOCK_BITS-1:0] d2_quot;
    logic [HW-1:0]         d2_rem;
    logic [SIDE2W-1:0]     d2_side;

    atab_div_pipe #(
        .DIVIDEND_W (BLOCK_BITS),
        .DIVISOR_W  (HW),
        .SIDE_W     (SIDE2W)
    ) u_div_heads (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (d1_valid),
        .dividend  (d1_quot),
        .divisor   (heads_reg),
        .side_in   ({d1_side, d1_rem}),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .remainder (d2_rem),
        .side_out  (d2_side)
    );

    // ------------------------------------------------------------------
    // Assemble the task-file bytes and register them.
    // ------------------------------------------------------------------
    logic                  f_cmd;
    logic [7:0]            f_count;
    logic [BLOCK_BITS-1:0] f_block_raw;
    logic [SW-1:0]         f_sec_rem;
    logic [27:0]           f_block;
    logic [31:0]           f_cyl;
    logic [7:0]            sec_byte;
    logic [7:0]            clo_byte;
    logic [7:0]            chi_byte;
    logic [7:0]            dh_byte;
    logic [7:0]            cmd_byte;
    logic                  err_bit;
    logic [47:0]           m_tdata_next;
    logic [47:0]           m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  m_tvalid_reg;

    assign {f_cmd, f_count, f_block_raw, f_sec_rem} = d2_side;
    assign f_block = 28'(f_block_raw);
    assign f_cyl   = 32'(d2_quot);

    always_comb begin
        if (lba_mode_reg) begin
            sec_byte = f_block[7:0];
            clo_byte = f_block[15:8];
            chi_byte = f_block[23:16];
            dh_byte  = drive_base_reg | atab_pkg::LBA_FLAG | {4'h0, f_block[27:24]};
            err_bit  = 1'b0;
        end else begin
            sec_byte = 8'(f_sec_rem) + 8'd1;
            clo_byte = f_cyl[7:0];
            chi_byte = f_cyl[15:8];
            dh_byte  = drive_base_reg | {4'h0, d2_rem[3:0]};
            err_bit  = (f_cyl > 32'h0000_FFFF);
        end
        cmd_byte     = f_cmd ? atab_pkg::OPC_WRITE_SECTORS : atab_pkg::OPC_READ_SECTORS;
        m_tdata_next = {cmd_byte, dh_byte, chi_byte, clo_byte, sec_byte, f_count};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= d2_valid;
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= err_bit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // Normalised divisors never leave their legal ranges
    a_heads_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (heads_reg != '0) && (heads_reg <= atab_pkg::MAX_HEADS))
        else $error("head count divisor out of range");

    a_spt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        spt_reg != '0)
        else $error("sectors per track divisor is zero");

    // Any presented result carries one of the two command codes
    a_cmd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:40] == atab_pkg::OPC_READ_SECTORS ||
                      m_tdata[47:40] == atab_pkg::OPC_WRITE_SECTORS))
        else $error("result carries an unknown command code");

    // Reset empties the output stage
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
